>>> hdl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, codes, round constants and SHA-256 helper functions for the
// byte-stream SHA-256 hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

    // Request command codes
    localparam logic [1:0] CMD_ABSORB        = 2'd0;
    localparam logic [1:0] CMD_ABSORB_FINISH = 2'd1;
    localparam logic [1:0] CMD_FINISH        = 2'd2;

    // Step counter of one compression: read, schedule and round overlap
    localparam logic [6:0]  STEP_FIRST_SCHED = 7'd1;
    localparam logic [6:0]  STEP_LAST_SCHED  = 7'd64;
    localparam logic [6:0]  STEP_FIRST_ROUND = 7'd2;
    localparam logic [6:0]  STEP_LAST_ROUND  = 7'd65;

    // Byte position from which the length field starts in a padded block
    localparam logic [5:0]  LEN_POS    = 6'd56;
    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam logic [6:0]  FULL_LIMIT = 7'd64;
    localparam logic [2:0]  LAST_INDEX = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_ADD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MODE_FULL,
        MODE_PAD_A,
        MODE_PAD_B
    } mode_t;

    // How the sixteen message words of a block are formed
    typedef struct packed {
        logic [6:0] limit;   // bytes below this come from the buffer
        logic       mark;    // put the 0x80 marker at byte position limit
        logic       len_en;  // put the bit length in the last eight bytes
    } pad_t;

    // Controls from the sequencer to the round unit
    typedef struct packed {
        logic init;   // return hash words to the initial values
        logic load;   // copy hash words into the working variables
        logic step;   // run one round
        logic add;    // fold working variables into the hash words
    } rnd_ctl_t;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

>>> hdl/shs_sched.sv
// ----------------------------------------------------------------------------
// shs_sched
// Message schedule: forms one padded or expanded message word per step from
// a sixteen-word sliding window and registers it with its round constant.
// ----------------------------------------------------------------------------
module shs_sched
(
    input  logic              clk,
    input  logic              en,
    input  logic [5:0]        idx,
    input  logic [31:0]       mem_word,
    input  shs_pkg::pad_t     pad,
    input  logic [63:0]       msg_len,
    output logic [31:0]       wk
);

    logic [31:0] win_reg [16];
    logic [31:0] wk_reg;
    logic [31:0] pad_word;
    logic [31:0] exp_word;
    logic [31:0] w;

    // Build a block word byte by byte: buffer, marker, length or zero
    always_comb
    begin
        logic [5:0] p;
        logic [5:0] len_sel;
        pad_word = '0;
        for (int i = 0; i < 4; i++)
        begin
            p       = {idx[3:0], 2'(i)};
            len_sel = {~p[2:0], 3'b000};
            if ({1'b0, p} < pad.limit)
            begin
                pad_word[(3 - i) * 8 +: 8] = mem_word[(3 - i) * 8 +: 8];
            end
            else if (pad.mark && ({1'b0, p} == pad.limit))
            begin
                pad_word[(3 - i) * 8 +: 8] = shs_pkg::PAD_MARK;
            end
            else if (pad.len_en && (p >= shs_pkg::LEN_POS))
            begin
                pad_word[(3 - i) * 8 +: 8] = msg_len[len_sel +: 8];
            end
        end
    end

    // Expand from the window once the sixteen block words are in
    assign exp_word = shs_pkg::small_sigma1(win_reg[14]) + win_reg[9]
                    + shs_pkg::small_sigma0(win_reg[1]) + win_reg[0];
    assign w        = (idx[5:4] == 2'b00) ? pad_word : exp_word;

    // Advance the window and hold the word plus constant for the round unit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w;
            wk_reg      <= w + shs_pkg::ROUND_K[idx];
        end
    end

    assign wk = wk_reg;

endmodule

>>> hdl/shs_round.sv
// ----------------------------------------------------------------------------
// shs_round
// Round unit: eight working variables updated one round per cycle, and the
// eight chaining hash words that collect each block's result.
// ----------------------------------------------------------------------------
module shs_round
(
    input  logic                clk,
    input  logic                rst_n,
    input  shs_pkg::rnd_ctl_t   ctl,
    input  logic [31:0]         wk,
    input  logic [2:0]          out_idx,
    output logic [31:0]         digest_word
);

    logic [31:0] hash_reg [8];
    logic [31:0] work_reg [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    // One SHA-256 round on the working variables
    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
    assign t1  = work_reg[7] + shs_pkg::big_sigma1(work_reg[4]) + ch + wk;
    assign t2  = shs_pkg::big_sigma0(work_reg[0]) + maj;

    // Hold the chaining value; fold in a finished block or restart it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= shs_pkg::INIT_H[i];
            end
        end
        else if (ctl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= shs_pkg::INIT_H[i];
            end
        end
        else if (ctl.add)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= hash_reg[i] + work_reg[i];
            end
        end
    end

    // Load the working variables, then advance one round per step
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i] <= hash_reg[i];
            end
        end
        else if (ctl.step)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    assign digest_word = hash_reg[out_idx];

endmodule

>>> hdl/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 of a byte stream, one byte per request, digest out as eight words.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tuser carries the command (absorb, absorb then finish,
// finish alone), s_tdata the message byte. An absorb that does not fill the
// 64-byte block leaves the block ready for the next byte. The byte that
// fills a block starts a compression by the single round unit, one round
// per cycle with the schedule word read and expanded ahead, then a fold into
// the hash words; s_tready stays low meanwhile.
// A finish pads the held bytes and compresses one or two more blocks
// (and first the full block if its own byte completed one), then offers
// the digest on m_*: eight words, index 0 most significant, m_tlast on the
// eighth. Each word holds until m_tready is high; a stalled receiver simply
// keeps the block in its output phase, and no new request is taken until the
// last word has gone. After that the hash words return to the initial values.
// Reset (rst_n low, asynchronous) loads the initial hash values, empties the
// byte count and the length count, and leaves the block idle and ready.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [1:0]  s_tuser,    // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [31:0] digest_word, [34:32] word_index, pad
    output logic        m_tlast     // last_word
);

    shs_pkg::state_t    state_reg, state_next;
    shs_pkg::mode_t     mode_reg, mode_next;
    logic [5:0]         fill_reg, fill_next;
    logic [54:0]        blk_cnt_reg, blk_cnt_next;
    logic               fin_pend_reg, fin_pend_next;
    logic [6:0]         step_reg, step_next;
    logic [2:0]         out_idx_reg, out_idx_next;

    logic [31:0]        buf_mem [16];
    logic [31:0]        rd_word_reg;
    logic               in_fire;
    logic               out_fire;
    logic               wr_en;
    logic               sched_en;
    logic [5:0]         sched_idx;
    logic [63:0]        msg_len;
    logic [31:0]        digest_word;
    logic [31:0]        wk;
    shs_pkg::pad_t      pad;
    shs_pkg::rnd_ctl_t  rnd_ctl;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign wr_en    = in_fire && ((s_tuser == shs_pkg::CMD_ABSORB)
                               || (s_tuser == shs_pkg::CMD_ABSORB_FINISH));

    // Write the byte into its big-endian lane; read one word per step
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_mem[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= s_tdata;
        end
        rd_word_reg <= buf_mem[step_reg[3:0]];
    end

    // Message length in bits: whole blocks, then the held bytes
    assign msg_len = {blk_cnt_reg, fill_reg, 3'b000};

    // Word formation for the block in progress
    always_comb
    begin
        pad = '{limit: shs_pkg::FULL_LIMIT, mark: 1'b0, len_en: 1'b0};
        case (mode_reg)
            shs_pkg::MODE_FULL:
            begin
                pad = '{limit: shs_pkg::FULL_LIMIT, mark: 1'b0, len_en: 1'b0};
            end
            shs_pkg::MODE_PAD_A:
            begin
                pad = '{limit: {1'b0, fill_reg}, mark: 1'b1,
                        len_en: (fill_reg < shs_pkg::LEN_POS)};
            end
            shs_pkg::MODE_PAD_B:
            begin
                pad = '{limit: '0, mark: 1'b0, len_en: 1'b1};
            end
            default:
            begin
                pad = '{limit: shs_pkg::FULL_LIMIT, mark: 1'b0, len_en: 1'b0};
            end
        endcase
    end

    assign sched_en  = (state_reg == shs_pkg::ST_RUN)
                    && (step_reg >= shs_pkg::STEP_FIRST_SCHED)
                    && (step_reg <= shs_pkg::STEP_LAST_SCHED);
    assign sched_idx = step_reg[5:0] - 6'd1;

    // Sequencer: absorb, run compressions, then hand out the digest
    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        fill_next     = fill_reg;
        blk_cnt_next  = blk_cnt_reg;
        fin_pend_next = fin_pend_reg;
        step_next     = step_reg;
        out_idx_next  = out_idx_reg;
        rnd_ctl       = '0;
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;

        case (state_reg)
            shs_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                step_next = '0;
                if (in_fire)
                begin
                    case (s_tuser)
                        shs_pkg::CMD_ABSORB, shs_pkg::CMD_ABSORB_FINISH:
                        begin
                            fill_next = fill_reg + 6'd1;
                            if (fill_reg == 6'd63)
                            begin
                                // block full: compress it, then finish if the command asked for it
                                mode_next     = shs_pkg::MODE_FULL;
                                fin_pend_next = (s_tuser == shs_pkg::CMD_ABSORB_FINISH);
                                state_next    = shs_pkg::ST_RUN;
                            end
                            else if (s_tuser == shs_pkg::CMD_ABSORB_FINISH)
                            begin
                                mode_next  = shs_pkg::MODE_PAD_A;
                                state_next = shs_pkg::ST_RUN;
                            end
                        end
                        shs_pkg::CMD_FINISH:
                        begin
                            mode_next  = shs_pkg::MODE_PAD_A;
                            state_next = shs_pkg::ST_RUN;
                        end
                        default:
                        begin
                            // unused command: drop it
                            state_next = shs_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            shs_pkg::ST_RUN:
            begin
                rnd_ctl.load = (step_reg == '0);
                rnd_ctl.step = (step_reg >= shs_pkg::STEP_FIRST_ROUND);
                step_next    = step_reg + 7'd1;
                if (step_reg == shs_pkg::STEP_LAST_ROUND)
                begin
                    state_next = shs_pkg::ST_ADD;
                end
            end

            shs_pkg::ST_ADD:
            begin
                rnd_ctl.add = 1'b1;
                step_next   = '0;
                case (mode_reg)
                    shs_pkg::MODE_FULL:
                    begin
                        blk_cnt_next = blk_cnt_reg + 55'd1;
                        if (fin_pend_reg)
                        begin
                            fin_pend_next = 1'b0;
                            mode_next     = shs_pkg::MODE_PAD_A;
                            state_next    = shs_pkg::ST_RUN;
                        end
                        else
                        begin
                            state_next = shs_pkg::ST_IDLE;
                        end
                    end
                    shs_pkg::MODE_PAD_A:
                    begin
                        if (fill_reg >= shs_pkg::LEN_POS)
                        begin
                            mode_next  = shs_pkg::MODE_PAD_B;
                            state_next = shs_pkg::ST_RUN;
                        end
                        else
                        begin
                            state_next = shs_pkg::ST_EMIT;
                        end
                    end
                    default:
                    begin
                        state_next = shs_pkg::ST_EMIT;
                    end
                endcase
            end

            shs_pkg::ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (out_fire)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == shs_pkg::LAST_INDEX)
                    begin
                        // restart for the next message
                        rnd_ctl.init = 1'b1;
                        fill_next    = '0;
                        blk_cnt_next = '0;
                        state_next   = shs_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = shs_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= shs_pkg::ST_IDLE;
            mode_reg     <= shs_pkg::MODE_FULL;
            fill_reg     <= '0;
            blk_cnt_reg  <= '0;
            fin_pend_reg <= 1'b0;
            step_reg     <= '0;
            out_idx_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            fill_reg     <= fill_next;
            blk_cnt_reg  <= blk_cnt_next;
            fin_pend_reg <= fin_pend_next;
            step_reg     <= step_next;
            out_idx_reg  <= out_idx_next;
        end
    end

    shs_sched u_sched
    (
        .clk      (clk),
        .en       (sched_en),
        .idx      (sched_idx),
        .mem_word (rd_word_reg),
        .pad      (pad),
        .msg_len  (msg_len),
        .wk       (wk)
    );

    shs_round u_round
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (rnd_ctl),
        .wk          (wk),
        .out_idx     (out_idx_reg),
        .digest_word (digest_word)
    );

    // Present the digest word with its position
    assign m_tdata = {5'd0, out_idx_reg, digest_word};
    assign m_tlast = (out_idx_reg == shs_pkg::LAST_INDEX);

endmodule

>>> tb/tb_sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher_core
// Self-checking bench for the byte-stream SHA-256 hasher. Messages of many
// lengths go in one byte per request, around the padding limits included,
// with the sender idling in bursts and the digest receiver stalling. A local
// SHA-256 predictor works out the eight digest words per finish, and each
// word that leaves is checked against the oldest one still due.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher_core;

    // Command code that the block drops without effect
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam int         LEN_START   = 56;
    localparam int         BLOCK_BYTES = 64;
    localparam int         ITEM_TARGET = 370;
    localparam int         MAX_SHOWN   = 10;
    localparam int         DRAIN_WAIT  = 300;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] data;
    } hash_req_t;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;     // [7:0] data_byte
    logic [1:0]  s_tuser = 2'd0;     // [1:0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;            // [31:0] digest_word, [34:32] word_index, pad
    logic        m_tlast;

    // Predictor state
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    int          fill_cnt;
    logic [63:0] bits_done;

    hash_req_t    req_queue [$];
    digest_word_t digest_due [$];
    int           n_items;
    int           n_errors;

    // Sender and receiver pacing
    int       burst_left;
    int       gap_left;
    rx_mode_t rx_mode;
    int       rx_mode_left;
    int       rx_cyc;

    sha256_stream_hasher_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] rotr32(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // Compress the held 64-byte block into the running hash words
    function automatic void hash_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] s0, s1, t1, t2;
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
            begin
                w[t] = {msg_block[4 * t], msg_block[4 * t + 1],
                        msg_block[4 * t + 2], msg_block[4 * t + 3]};
            end
            else
            begin
                s0 = rotr32(w[t - 15], 7) ^ rotr32(w[t - 15], 18) ^ (w[t - 15] >> 3);
                s1 = rotr32(w[t - 2], 17) ^ rotr32(w[t - 2], 19) ^ (w[t - 2] >> 10);
                w[t] = s1 + w[t - 7] + s0 + w[t - 16];
            end
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int t = 0; t < 64; t++)
        begin
            t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) + ((e & f) ^ (~e & g))
                 + SHA_K[t] + w[t];
            t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] = SHA_H0[i];
        end
        fill_cnt = 0;
        bits_done = 64'd0;
    endfunction

    function automatic void take_byte(input logic [7:0] v);
        msg_block[fill_cnt] = v;
        fill_cnt++;
        if (fill_cnt == BLOCK_BYTES)
        begin
            hash_block();
            fill_cnt = 0;
            bits_done += 64'd512;
        end
    endfunction

    // Pad, append the bit length and queue the eight digest words
    function automatic void close_message();
        int          n;
        logic [63:0] len;
        digest_word_t dw;
        n = fill_cnt;
        len = bits_done + 64'(n) * 64'd8;
        msg_block[n] = PAD_BYTE;
        n++;
        if (n > LEN_START)
        begin
            while (n < BLOCK_BYTES)
            begin
                msg_block[n] = 8'd0;
                n++;
            end
            hash_block();
            n = 0;
        end
        while (n < LEN_START)
        begin
            msg_block[n] = 8'd0;
            n++;
        end
        for (int i = 0; i < 8; i++)
        begin
            msg_block[LEN_START + i] = len[63 - 8 * i -: 8];
        end
        hash_block();
        for (int i = 0; i < 8; i++)
        begin
            dw.word = hash_state[i];
            dw.idx  = 3'(i);
            dw.last = (3'(i) == shs_pkg::LAST_INDEX);
            digest_due.push_back(dw);
        end
        restart_message();
    endfunction

    function automatic void apply_request(input hash_req_t r);
        case (r.cmd)
            shs_pkg::CMD_ABSORB:        take_byte(r.data);
            shs_pkg::CMD_ABSORB_FINISH:
            begin
                take_byte(r.data);
                close_message();
            end
            shs_pkg::CMD_FINISH:        close_message();
            default:                    ;  // unused code: drop
        endcase
    endfunction

    function automatic void add_request(input logic [1:0] cmd, input logic [7:0] data);
        hash_req_t r;
        r.cmd = cmd;
        r.data = data;
        req_queue.push_back(r);
        if (cmd != CMD_UNUSED)
        begin
            n_items++;
        end
    endfunction

    // Queue one message of random bytes, closed by a final byte or a bare finish
    function automatic void add_message(input int len);
        logic with_byte;
        with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                add_request(CMD_UNUSED, 8'($urandom));
            end
            add_request((with_byte && i == len - 1) ? shs_pkg::CMD_ABSORB_FINISH
                                                    : shs_pkg::CMD_ABSORB,
                        8'($urandom));
        end
        if (!with_byte)
        begin
            add_request(shs_pkg::CMD_FINISH, 8'($urandom));
        end
    endfunction

    function automatic int pick_length();
        int sel;
        int edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        sel = $urandom_range(0, 9);
        if (sel < 7)
        begin
            return $urandom_range(0, 24);
        end
        else if (sel < 9)
        begin
            return edges[$urandom_range(0, 7)];
        end
        return $urandom_range(66, 130);
    endfunction

    task automatic report_mismatch(input string what, input digest_word_t want,
                                   input digest_word_t got);
        n_errors++;
        if (n_errors <= MAX_SHOWN)
        begin
            $display("%s: expected word %h index %0d last %b, got word %h index %0d last %b",
                     what, want.word, want.idx, want.last, got.word, got.idx, got.last);
        end
    endtask

    // Drive requests from the queue in bursts; hold each until it is taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                apply_request(req_queue.pop_front());
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (req_queue.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= req_queue[0].data;
                    s_tuser  <= req_queue[0].cmd;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check each digest word and pace the receiver
    always @(posedge clk)
    begin
        digest_word_t got;
        digest_word_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.word = m_tdata[31:0];
                got.idx  = m_tdata[34:32];
                got.last = m_tlast;
                if (digest_due.size() == 0)
                begin
                    want = '{word: 32'd0, idx: 3'd0, last: 1'b0};
                    report_mismatch("digest word with none due", want, got);
                end
                else
                begin
                    want = digest_due.pop_front();
                    if (got.word !== want.word || got.idx !== want.idx
                        || got.last !== want.last)
                    begin
                        report_mismatch("digest word mismatch", want, got);
                    end
                end
            end
            rx_cyc++;
            if (rx_mode_left <= 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 200);
            end
            else
            begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_FREE:     m_tready <= 1'b1;
                RX_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
                RX_PERIODIC: m_tready <= ((rx_cyc % 3) != 0);
                default:     m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        n_items = 0;
        n_errors = 0;
        burst_left = 0;
        gap_left = 0;
        rx_mode = RX_FREE;
        rx_mode_left = 0;
        rx_cyc = 0;
        restart_message();
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            msg_block[i] = 8'd0;
        end

        // Empty messages back to back, single bytes at both extremes
        add_request(shs_pkg::CMD_FINISH, 8'hff);
        add_request(shs_pkg::CMD_FINISH, 8'h00);
        add_request(shs_pkg::CMD_ABSORB_FINISH, 8'h00);
        add_request(shs_pkg::CMD_ABSORB_FINISH, 8'hff);
        // Short message with an unused command inside, closed by a final byte
        add_request(shs_pkg::CMD_ABSORB, 8'h61);
        add_request(CMD_UNUSED, 8'h5a);
        add_request(shs_pkg::CMD_ABSORB, 8'h62);
        add_request(shs_pkg::CMD_ABSORB_FINISH, 8'h63);
        // Same bytes closed by a bare finish
        add_request(shs_pkg::CMD_ABSORB, 8'h61);
        add_request(shs_pkg::CMD_ABSORB, 8'h62);
        add_request(shs_pkg::CMD_ABSORB, 8'h63);
        add_request(shs_pkg::CMD_FINISH, 8'h00);
        add_request(CMD_UNUSED, 8'hff);

        while (n_items < ITEM_TARGET)
        begin
            add_message(pick_length());
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (req_queue.size() > 0)
        begin
            @(posedge clk);
        end
        while (digest_due.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        if (n_errors == 0 && digest_due.size() == 0)
        begin
            $display("tb_sha256_stream_hasher_core OK");
        end
        else
        begin
            $display("tb_sha256_stream_hasher_core NOT OK");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #4000000;
        $display("tb_sha256_stream_hasher_core NOT OK");
        $finish;
    end

endmodule
